>>> rtl/srfl_pkg.sv
// Shared constants, codes and types of the slot range free list allocator.
package srfl_pkg;

    localparam int MAX_HEAPS  = 8;
    localparam int MAX_RANGES = 16;

    // Fixed field widths.
    localparam int OFF_W     = 16;
    localparam int RNG_W     = 17;
    localparam int HFIELD_W  = 3;
    localparam int SLOTS_W   = 11;
    localparam int DS_W      = 7;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;

    // Widths that follow from the table sizes.
    localparam int HEAP_W = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
    localparam int RIDX_W = $clog2(MAX_RANGES);
    localparam int RCNT_W = $clog2(MAX_RANGES + 1);
    localparam int OPEN_W = $clog2(MAX_HEAPS + 1);
    localparam int ADDR_W = HEAP_W + RIDX_W;
    localparam int DEPTH  = MAX_HEAPS * MAX_RANGES;
    localparam int SUM_W  = RNG_W + 1;
    localparam int PROD_W = SLOTS_W + DS_W;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK       = 2'd0,
        ST_NO_HEAP  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_OPEN = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_SLOTS = 1'b0,
        CFG_DSIZE = 1'b1
    } cfg_reg_t;

    // One free range [start_off, end_off) of a heap.
    typedef struct packed
    {
        logic [RNG_W-1:0] start_off;
        logic [RNG_W-1:0] end_off;
    } range_t;

    typedef struct packed
    {
        op_t                 opcode;
        logic [HFIELD_W-1:0] heap_index;
        logic [OFF_W-1:0]    slot_offset;
    } req_t;

    typedef struct packed
    {
        logic [HFIELD_W-1:0] heap;
        logic [OFF_W-1:0]    offset;
        status_t             status;
    } res_t;

endpackage

>>> rtl/srfl_ram.sv
// Generic single write port, single read port RAM with registered read data.
module srfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/srfl_seq.sv
// Sequencer that walks and shifts the range tables one entry per cycle.
module srfl_seq
    import srfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    input  logic [SLOTS_W-1:0] eff_slots,
    input  logic [DS_W-1:0]   eff_dsize,
    output logic              res_valid,
    input  logic              res_ack,
    output res_t              res,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output range_t            ram_wdata,
    output logic [ADDR_W-1:0] ram_raddr,
    input  range_t            ram_rdata
);

    typedef enum logic [9:0]
    {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_NEWH  = 10'b0000001000,
        S_HEAD  = 10'b0000010000,
        S_DROP  = 10'b0000100000,
        S_WALK  = 10'b0001000000,
        S_SHIFT = 10'b0010000000,
        S_PLACE = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [HFIELD_W-1:0] fheap_reg, fheap_next;
    logic [HEAP_W-1:0]   heap_reg, heap_next;
    logic [RNG_W-1:0]    ns_reg, ns_next;
    logic [RNG_W-1:0]    ne_reg, ne_next;
    logic [RCNT_W-1:0]   cnt_reg, cnt_next;
    logic [RIDX_W-1:0]   idx_reg, idx_next;
    logic [RIDX_W-1:0]   sh_reg, sh_next;
    logic [OPEN_W-1:0]   open_reg, open_next;
    logic [RCNT_W-1:0]   count_reg [MAX_HEAPS];
    logic [RCNT_W-1:0]   count_next [MAX_HEAPS];
    res_t                res_reg, res_next;

    logic                found_any;
    logic [HEAP_W-1:0]   found_idx;
    logic [HEAP_W-1:0]   free_heap;
    logic [SUM_W-1:0]    add_a;
    logic [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]   prod;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign free_heap = HEAP_W'(fheap_reg);

    // The one adder: the free end on accept, the advanced front start on allocate.
    assign add_a = (state_reg == S_IDLE) ? SUM_W'(req.slot_offset) : SUM_W'(ram_rdata.start_off);
    assign sum   = add_a + SUM_W'(eff_dsize);
    assign prod  = PROD_W'(eff_slots) * PROD_W'(eff_dsize);

    // Lowest heap that still holds a free range; unopened heaps hold none.
    always_comb
    begin
        found_any = 1'b0;
        found_idx = '0;
        for (int h = MAX_HEAPS - 1; h >= 0; h--)
        begin
            if (count_reg[h] != '0)
            begin
                found_any = 1'b1;
                found_idx = HEAP_W'(h);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        fheap_next = fheap_reg;
        heap_next  = heap_reg;
        ns_next    = ns_reg;
        ne_next    = ne_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        sh_next    = sh_reg;
        open_next  = open_reg;
        count_next = count_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = {heap_reg, idx_reg};
        ram_wdata  = '0;
        ram_raddr  = {heap_reg, idx_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    fheap_next = req.heap_index;
                    ns_next    = RNG_W'(req.slot_offset);
                    ne_next    = sum[RNG_W-1:0];
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_next = '0;
                if (op_reg == OP_ALLOC)
                begin
                    if (found_any)
                    begin
                        heap_next  = found_idx;
                        cnt_next   = count_reg[found_idx];
                        ram_raddr  = {found_idx, RIDX_W'(0)};
                        state_next = S_HEAD;
                    end
                    else if (open_reg == OPEN_W'(MAX_HEAPS))
                    begin
                        res_next.status = ST_NO_HEAP;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        heap_next  = open_reg[HEAP_W-1:0];
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    if (int'(fheap_reg) >= int'(open_reg))
                    begin
                        res_next.status = ST_NOT_OPEN;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        heap_next = free_heap;
                        cnt_next  = count_reg[free_heap];
                        idx_next  = '0;
                        ram_raddr = {free_heap, RIDX_W'(0)};
                        // An empty table takes the slot as its only range.
                        if (count_reg[free_heap] == '0)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_MUL:
            begin
                ne_next    = prod[RNG_W-1:0];
                state_next = S_NEWH;
            end

            S_NEWH:
            begin
                open_next       = open_reg + OPEN_W'(1);
                res_next.heap   = HFIELD_W'(heap_reg);
                res_next.offset = '0;
                // The first slot is granted at once; a one slot heap is used up.
                if (RNG_W'(eff_dsize) < ne_reg)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = {heap_reg, RIDX_W'(0)};
                    ram_wdata.start_off = RNG_W'(eff_dsize);
                    ram_wdata.end_off   = ne_reg;
                    count_next[heap_reg] = RCNT_W'(1);
                end
                state_next = S_DONE;
            end

            S_HEAD:
            begin
                res_next.heap   = HFIELD_W'(heap_reg);
                res_next.offset = ram_rdata.start_off[OFF_W-1:0];
                ram_raddr       = {heap_reg, RIDX_W'(1)};
                if ((sum >= SUM_W'(ram_rdata.end_off)) || (sum[SUM_W-1:OFF_W] != '0))
                begin
                    count_next[heap_reg] = count_reg[heap_reg] - RCNT_W'(1);
                    sh_next              = '0;
                    if (cnt_reg > RCNT_W'(1))
                    begin
                        state_next = S_DROP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = {heap_reg, RIDX_W'(0)};
                    ram_wdata.start_off = sum[RNG_W-1:0];
                    ram_wdata.end_off   = ram_rdata.end_off;
                    state_next          = S_DONE;
                end
            end

            S_DROP:
            begin
                // Read data is entry sh + 1, moved down into entry sh.
                ram_we    = 1'b1;
                ram_waddr = {heap_reg, sh_reg};
                ram_wdata = ram_rdata;
                ram_raddr = {heap_reg, sh_reg + RIDX_W'(2)};
                if ((RCNT_W'(sh_reg) + RCNT_W'(2)) >= cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sh_next = sh_reg + RIDX_W'(1);
                end
            end

            S_WALK:
            begin
                ram_raddr = {heap_reg, idx_reg + RIDX_W'(1)};
                if (ram_rdata.start_off == ne_reg)
                begin
                    ram_we              = 1'b1;
                    ram_wdata.start_off = ns_reg;
                    ram_wdata.end_off   = ram_rdata.end_off;
                    state_next          = S_DONE;
                end
                else if (ram_rdata.end_off == ns_reg)
                begin
                    ram_we              = 1'b1;
                    ram_wdata.start_off = ram_rdata.start_off;
                    ram_wdata.end_off   = ne_reg;
                    state_next          = S_DONE;
                end
                else if (ram_rdata.start_off > ns_reg)
                begin
                    if (cnt_reg == RCNT_W'(MAX_RANGES))
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // Open a hole at idx by moving the tail up, top entry first.
                        sh_next    = cnt_reg[RIDX_W-1:0];
                        ram_raddr  = {heap_reg, cnt_reg[RIDX_W-1:0] - RIDX_W'(1)};
                        state_next = S_SHIFT;
                    end
                end
                else if ((RCNT_W'(idx_reg) + RCNT_W'(1)) == cnt_reg)
                begin
                    if (cnt_reg == RCNT_W'(MAX_RANGES))
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = cnt_reg[RIDX_W-1:0];
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + RIDX_W'(1);
                end
            end

            S_SHIFT:
            begin
                // Read data is entry sh - 1, moved up into entry sh.
                ram_we    = 1'b1;
                ram_waddr = {heap_reg, sh_reg};
                ram_wdata = ram_rdata;
                ram_raddr = {heap_reg, sh_reg - RIDX_W'(2)};
                if ((sh_reg - RIDX_W'(1)) == idx_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    sh_next = sh_reg - RIDX_W'(1);
                end
            end

            S_PLACE:
            begin
                ram_we               = 1'b1;
                ram_waddr            = {heap_reg, idx_reg};
                ram_wdata.start_off  = ns_reg;
                ram_wdata.end_off    = ne_reg;
                count_next[heap_reg] = count_reg[heap_reg] + RCNT_W'(1);
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            open_reg  <= '0;
            for (int h = 0; h < MAX_HEAPS; h++)
            begin
                count_reg[h] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        fheap_reg <= fheap_next;
        heap_reg  <= heap_next;
        ns_reg    <= ns_next;
        ne_reg    <= ne_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        sh_reg    <= sh_next;
        res_reg   <= res_next;
    end

endmodule

>>> rtl/slot_range_free_list_allocator.sv
// Top level of the slot range free list allocator: config, sequencer, range table RAM, result register.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, heap_index,         | to block
//          | slot_offset                                     |
//  out     | out_valid, out_ready, granted_heap,             | from block
//          | granted_offset, status                          |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | to block
//
// A word that fails at once goes from the start state straight to its result; an allocate
// that opens a heap first multiplies out the heap size, another allocate moves the ranges
// down once the front range is used up, and a free walks the ranges and may move the tail up.
// Every entry passes through the range table RAM, one read and one write per cycle.
// Reset clears the open heap count and the range counts; the RAM itself is not cleared.
// A finished result sits in the output register, so the next word is taken while it waits.
module slot_range_free_list_allocator
    import srfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [HFIELD_W-1:0]  heap_index,
    input  logic [OFF_W-1:0]     slot_offset,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HFIELD_W-1:0]  granted_heap,
    output logic [OFF_W-1:0]     granted_offset,
    output logic [STATUS_W-1:0]  status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam logic [SLOTS_W-1:0] SLOTS_MAX   = SLOTS_W'(1024);
    localparam logic [SLOTS_W-1:0] SLOTS_RESET = SLOTS_W'(256);
    localparam logic [DS_W-1:0]    DS_MAX      = DS_W'(64);
    localparam logic [DS_W-1:0]    DS_RESET    = DS_W'(32);

    logic [SLOTS_W-1:0] slots_reg;
    logic [DS_W-1:0]    dsize_reg;
    logic [SLOTS_W-1:0] eff_slots;
    logic [DS_W-1:0]    eff_dsize;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg;
    req_t               req;
    res_t               seq_res;
    logic               seq_res_valid;
    logic               seq_res_ack;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    range_t             ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    range_t             ram_rdata;

    assign cfg_ready = 1'b1;

    // Out of range settings are clamped into the usable range.
    always_comb
    begin
        priority if (slots_reg == '0)
        begin
            eff_slots = SLOTS_W'(1);
        end
        else if (slots_reg > SLOTS_MAX)
        begin
            eff_slots = SLOTS_MAX;
        end
        else
        begin
            eff_slots = slots_reg;
        end

        priority if (dsize_reg == '0)
        begin
            eff_dsize = DS_W'(1);
        end
        else if (dsize_reg > DS_MAX)
        begin
            eff_dsize = DS_MAX;
        end
        else
        begin
            eff_dsize = dsize_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
            dsize_reg <= DS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SLOTS: slots_reg <= cfg_data[SLOTS_W-1:0];
                CFG_DSIZE: dsize_reg <= cfg_data[DS_W-1:0];
                default:   slots_reg <= slots_reg;
            endcase
        end
    end

    assign req.opcode      = op_t'(opcode);
    assign req.heap_index  = heap_index;
    assign req.slot_offset = slot_offset;

    srfl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (req),
        .eff_slots (eff_slots),
        .eff_dsize (eff_dsize),
        .res_valid (seq_res_valid),
        .res_ack   (seq_res_ack),
        .res       (seq_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    srfl_ram #(
        .WIDTH ($bits(range_t)),
        .DEPTH (DEPTH)
    ) u_ranges (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register takes a result whenever it is empty or being emptied.
    assign seq_res_ack = seq_res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (seq_res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res_ack)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted_heap   = out_res_reg.heap;
    assign granted_offset = out_res_reg.offset;
    assign status         = out_res_reg.status;

endmodule

>>> dv/srfl_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the slot range free list allocator: predicts each result word and compares.
module srfl_result_checker
    import srfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 opcode,
    input  logic [HFIELD_W-1:0]  heap_index,
    input  logic [OFF_W-1:0]     slot_offset,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [HFIELD_W-1:0]  granted_heap,
    input  logic [OFF_W-1:0]     granted_offset,
    input  logic [STATUS_W-1:0]  status,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   errors,
    output int                   pending
);

    logic [SLOTS_W-1:0] slots_reg;
    logic [DS_W-1:0]    dsize_reg;
    int unsigned        heaps_open;
    int unsigned        range_cnt [MAX_HEAPS];
    logic [RNG_W-1:0]   range_lo  [MAX_HEAPS][MAX_RANGES];
    logic [RNG_W-1:0]   range_hi  [MAX_HEAPS][MAX_RANGES];
    res_t               expected_words [$];
    res_t               want;
    int                 words_seen;

    function automatic int unsigned stride();
        if (dsize_reg == 0)
            return 1;
        if (dsize_reg > 64)
            return 64;
        return dsize_reg;
    endfunction

    function automatic int unsigned heap_bytes();
        int unsigned n;
        n = slots_reg;
        if (n == 0)
            n = 1;
        else if (n > 1024)
            n = 1024;
        return n * stride();
    endfunction

    function automatic void drop_front(int h);
        for (int r = 0; r + 1 < range_cnt[h]; r++)
        begin
            range_lo[h][r] = range_lo[h][r+1];
            range_hi[h][r] = range_hi[h][r+1];
        end
        range_cnt[h]--;
    endfunction

    function automatic void insert_range(int h, int pos, int unsigned lo, int unsigned hi);
        for (int r = range_cnt[h]; r > pos; r--)
        begin
            range_lo[h][r] = range_lo[h][r-1];
            range_hi[h][r] = range_hi[h][r-1];
        end
        range_lo[h][pos] = RNG_W'(lo);
        range_hi[h][pos] = RNG_W'(hi);
        range_cnt[h]++;
    endfunction

    // Allocate: first heap with a free range, else open the next heap.
    function automatic res_t take_slot();
        res_t        r;
        int          found;
        int unsigned ds;
        int unsigned nxt;
        r = '0;
        r.status = ST_OK;
        ds = stride();
        found = -1;
        for (int h = 0; h < heaps_open; h++)
        begin
            if (range_cnt[h] > 0)
            begin
                found = h;
                break;
            end
        end
        if (found < 0)
        begin
            if (heaps_open >= MAX_HEAPS)
            begin
                r.status = ST_NO_HEAP;
                return r;
            end
            found = heaps_open;
            heaps_open++;
            range_cnt[found] = 1;
            range_lo[found][0] = '0;
            range_hi[found][0] = RNG_W'(heap_bytes());
        end
        r.heap = HFIELD_W'(found);
        r.offset = range_lo[found][0][OFF_W-1:0];
        nxt = range_lo[found][0] + ds;
        if (nxt >= range_hi[found][0] || nxt > 65535)
            drop_front(found);
        else
            range_lo[found][0] = RNG_W'(nxt);
        return r;
    endfunction

    // Free: merge into the first adjacent range, insert before the first
    // range above the slot, or append.
    function automatic res_t give_back(logic [HFIELD_W-1:0] h, logic [OFF_W-1:0] off);
        res_t        r;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        int          hh;
        r = '0;
        r.status = ST_OK;
        lo = off;
        hi = lo + stride();
        hh = h;
        if (hh >= heaps_open)
        begin
            r.status = ST_NOT_OPEN;
            return r;
        end
        n = range_cnt[hh];
        for (int i = 0; i < n; i++)
        begin
            if (range_lo[hh][i] == hi)
            begin
                range_lo[hh][i] = RNG_W'(lo);
                return r;
            end
            if (range_hi[hh][i] == lo)
            begin
                range_hi[hh][i] = RNG_W'(hi);
                return r;
            end
            if (range_lo[hh][i] > lo)
            begin
                if (n >= MAX_RANGES)
                    r.status = ST_FULL;
                else
                    insert_range(hh, i, lo, hi);
                return r;
            end
        end
        if (n >= MAX_RANGES)
            r.status = ST_FULL;
        else
            insert_range(hh, n, lo, hi);
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg = 11'd256;
            dsize_reg = 7'd32;
            heaps_open = 0;
            foreach (range_cnt[h])
                range_cnt[h] = 0;
            expected_words.delete();
            errors = 0;
            words_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report($sformatf("unexpected result word: heap %0d offset %0d status %0d",
                                     granted_heap, granted_offset, status));
                end
                else
                begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    if (granted_heap !== want.heap)
                        report($sformatf("word %0d granted_heap: got %0d, want %0d",
                                         words_seen, granted_heap, want.heap));
                    if (granted_offset !== want.offset)
                        report($sformatf("word %0d granted_offset: got %0d, want %0d",
                                         words_seen, granted_offset, want.offset));
                    if (status !== want.status)
                        report($sformatf("word %0d status: got %0d, want %0d",
                                         words_seen, status, want.status));
                end
                words_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_SLOTS: slots_reg = cfg_data[SLOTS_W-1:0];
                    CFG_DSIZE: dsize_reg = cfg_data[DS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (op_t'(opcode) == OP_FREE)
                    expected_words = {expected_words, give_back(heap_index, slot_offset)};
                else
                    expected_words = {expected_words, take_slot()};
            end
            pending <= expected_words.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the slot range free list allocator: stimulus, back-pressure and verdict.
module tb
    import srfl_pkg::*;
();

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 110;

    typedef struct packed
    {
        logic [HFIELD_W-1:0] heap;
        logic [OFF_W-1:0]    offset;
    } held_slot_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 opcode;
    logic [HFIELD_W-1:0]  heap_index;
    logic [OFF_W-1:0]     slot_offset;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [HFIELD_W-1:0]  granted_heap;
    logic [OFF_W-1:0]     granted_offset;
    logic [STATUS_W-1:0]  status;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int                   err_count;
    int                   pending_cnt;
    int                   cycle_cnt = 0;
    int                   stall_left = 0;
    bit                   calm;
    op_t                  sent_ops [$];
    op_t                  done_op;
    held_slot_t           held [$];

    slot_range_free_list_allocator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .heap_index     (heap_index),
        .slot_offset    (slot_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted_heap   (granted_heap),
        .granted_offset (granted_offset),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    srfl_result_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .heap_index     (heap_index),
        .slot_offset    (slot_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted_heap   (granted_heap),
        .granted_offset (granted_offset),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (err_count),
        .pending        (pending_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int unsigned p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Track granted slots so that most frees return a slot that is really held.
    // Sampled mid-cycle, where both handshakes are already settled for the next edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready && sent_ops.size() > 0)
        begin
            done_op = sent_ops[0];
            sent_ops.delete(0);
            if (done_op == OP_ALLOC && status == ST_OK)
                held = {held, held_slot_t'{heap: granted_heap, offset: granted_offset}};
        end
        if (rst_n && in_valid && in_ready)
            sent_ops = {sent_ops, op_t'(opcode)};
    end

    task automatic send_word(input op_t op, input logic [HFIELD_W-1:0] h,
                             input logic [OFF_W-1:0] off);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        heap_index  <= h;
        slot_offset <= off;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_alloc();
        send_word(OP_ALLOC, HFIELD_W'($urandom_range(0, 7)), OFF_W'($urandom_range(0, 65535)));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(data);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned slots, input int unsigned dsize);
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_SLOTS, slots);
            write_reg(CFG_DSIZE, dsize);
        end
        else
        begin
            write_reg(CFG_DSIZE, dsize);
            write_reg(CFG_SLOTS, slots);
        end
    endtask

    // Mostly allocations and frees of held slots; the rest are double frees
    // and frees at arbitrary heaps and offsets.
    task automatic random_item();
        int unsigned p;
        int          idx;
        held_slot_t  s;
        p = $urandom_range(0, 99);
        if (p < 42 || (held.size() == 0 && p < 90))
        begin
            send_alloc();
        end
        else if (p < 84)
        begin
            idx = $urandom_range(0, held.size() - 1);
            s = held[idx];
            held.delete(idx);
            send_word(OP_FREE, s.heap, s.offset);
        end
        else if (p < 90)
        begin
            s = held[$urandom_range(0, held.size() - 1)];
            send_word(OP_FREE, s.heap, s.offset);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: send_word(OP_FREE, HFIELD_W'($urandom_range(0, 7)), 16'hFFFF);
                1: send_word(OP_FREE, HFIELD_W'($urandom_range(0, 7)), 16'h0000);
                default: send_word(OP_FREE, HFIELD_W'($urandom_range(0, 7)),
                                   OFF_W'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = 1'b0;
        heap_index  = '0;
        slot_offset = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        calm        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Frees to heaps that are not open yet.
        send_word(OP_FREE, 3'd0, 16'h0000);
        send_word(OP_FREE, 3'd7, 16'hFFFF);

        // Zero registers act as one: seven one-slot heaps, each used up at once.
        wait_drain();
        set_config(0, 0);
        repeat (7) send_alloc();

        // The last heap holds two slots, then every heap is open and empty.
        wait_drain();
        set_config(2, 127);
        repeat (3) send_alloc();

        // Ranges at the top of the offset space; the advanced front start runs past 65535.
        send_word(OP_FREE, 3'd7, 16'hFFC0);
        send_word(OP_FREE, 3'd7, 16'hFFFF);
        send_alloc();
        send_alloc();

        // Merge below, merge above, insert in the middle.
        wait_drain();
        set_config(2047, 64);
        send_word(OP_FREE, 3'd3, 16'd0);
        send_word(OP_FREE, 3'd3, 16'd64);
        send_word(OP_FREE, 3'd3, 16'd320);
        send_word(OP_FREE, 3'd3, 16'd256);
        send_word(OP_FREE, 3'd3, 16'd4096);
        send_word(OP_FREE, 3'd3, 16'd2048);
        send_alloc();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drain();
            case (ph)
                0: set_config(1, 1);
                1: set_config(1024, 64);
                2: set_config(2047, 127);
                3: set_config(0, 0);
                4: set_config(256, 32);
                5: set_config(3, 5);
                6: set_config($urandom_range(1, 1024), $urandom_range(1, 64));
                default: set_config(2, 48);
            endcase
            calm <= (ph % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_drain();
                random_item();
            end
        end

        wait_drain();
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/srfl_pkg.sv
rtl/srfl_ram.sv
rtl/srfl_seq.sv
rtl/slot_range_free_list_allocator.sv
dv/srfl_result_checker.sv
dv/tb.sv
